// File: sv/bsfr_pkg.sv
// Shared types, constants and the CRC byte step for the byte-stuffed frame receiver.
// No dependencies; every other file refers to it by scoped names.
package bsfr_pkg;

   // Widths of the fields
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned CRC_W     = 16;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OK      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CRC_ERR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_ADDR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEGIN_FLAG   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_FLAG     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_XOR_MASK     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY     = 3'd5;

   // Register reset values
   localparam logic [BYTE_W-1:0] RST_STATION_ADDR = 8'h00;
   localparam logic [LEN_W-1:0]  RST_MAX_LEN      = 16'd512;
   localparam logic [BYTE_W-1:0] RST_BEGIN_FLAG   = 8'h7E;
   localparam logic [BYTE_W-1:0] RST_ESC_FLAG     = 8'h7D;
   localparam logic [BYTE_W-1:0] RST_XOR_MASK     = 8'h20;
   localparam logic [CRC_W-1:0]  RST_CRC_POLY     = 16'hA001;

   // Receiver phases, one-hot
   typedef enum logic [7:0] {
      PH_HUNT    = 8'b0000_0001,
      PH_SRC     = 8'b0000_0010,
      PH_DST     = 8'b0000_0100,
      PH_LEN_LO  = 8'b0000_1000,
      PH_LEN_HI  = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_CRC_LO  = 8'b0100_0000,
      PH_CRC_HI  = 8'b1000_0000
   } phase_type;

   // Configuration register set
   typedef struct packed {
      logic [BYTE_W-1:0] station_addr;
      logic [LEN_W-1:0]  max_len;
      logic [BYTE_W-1:0] begin_flag;
      logic [BYTE_W-1:0] esc_flag;
      logic [BYTE_W-1:0] xor_mask;
      logic [CRC_W-1:0]  crc_poly;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] src_addr;
      logic [LEN_W-1:0]  frame_len;
   } rsp_type;

   // Reflected CRC-16 over one byte, bit at a time
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [CRC_W-1:0]  poly);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: sv/bsfr_req_if.sv
// Input channel: one raw link byte per word, valid/ready handshake.
// Widths from bsfr_pkg.
interface bsfr_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsfr_pkg::BYTE_W-1:0]   raw_byte;

   modport source (output valid, output raw_byte, input ready);
   modport sink   (input valid, input raw_byte, output ready);
endinterface

// File: sv/bsfr_rsp_if.sv
// Result channel: payload bytes and end-of-frame status, valid/ready handshake.
// Widths from bsfr_pkg.
interface bsfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsfr_pkg::KIND_W-1:0]   kind;
   logic [bsfr_pkg::BYTE_W-1:0]   data;
   logic [bsfr_pkg::BYTE_W-1:0]   src_addr;
   logic [bsfr_pkg::LEN_W-1:0]    frame_len;

   modport source (output valid, output kind, output data, output src_addr,
                   output frame_len, input ready);
   modport sink   (input valid, input kind, input data, input src_addr,
                   input frame_len, output ready);
endinterface

// File: sv/byte_stuffed_frame_receiver_core.sv
// Byte-stuffed frame receiver: HDLC-like deframer with CRC-16 check.
// A byte accepted into the input register has its result, if any, loaded into the
// result register once the result side is free, and offered from there. The core
// takes one byte per cycle while the result side is not stalled.
// Synchronous active-high reset restores register defaults and the hunt phase.
// Depends on bsfr_pkg, bsfr_req_if, bsfr_rsp_if and bsfr_deframe.
module byte_stuffed_frame_receiver_core (
   input  logic                             clock,
   input  logic                             reset,
   bsfr_req_if.sink                         req_ch,
   bsfr_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [bsfr_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   bsfr_pkg::cfg_type               cfg_ff, cfg_in;
   logic                            in_valid_ff, in_valid_in;
   logic [bsfr_pkg::BYTE_W-1:0]     in_byte_ff, in_byte_in;
   logic                            out_valid_ff, out_valid_in;
   bsfr_pkg::rsp_type               out_ff, out_in;

   logic                            out_free;
   logic                            step;
   logic                            res_valid;
   bsfr_pkg::rsp_type               res;

   // Configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            bsfr_pkg::CSR_STATION_ADDR: cfg_in.station_addr = csr_wdata[bsfr_pkg::BYTE_W-1:0];
            bsfr_pkg::CSR_MAX_LEN:      cfg_in.max_len      = csr_wdata[bsfr_pkg::LEN_W-1:0];
            bsfr_pkg::CSR_BEGIN_FLAG:   cfg_in.begin_flag   = csr_wdata[bsfr_pkg::BYTE_W-1:0];
            bsfr_pkg::CSR_ESC_FLAG:     cfg_in.esc_flag     = csr_wdata[bsfr_pkg::BYTE_W-1:0];
            bsfr_pkg::CSR_XOR_MASK:     cfg_in.xor_mask     = csr_wdata[bsfr_pkg::BYTE_W-1:0];
            bsfr_pkg::CSR_CRC_POLY:     cfg_in.crc_poly     = csr_wdata[bsfr_pkg::CRC_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input register drains whenever the result register can load
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         in_byte_in  = req_ch.raw_byte;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = step && res_valid;
         out_in       = res;
      end
   end

   bsfr_deframe u_deframe (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .raw_byte  (in_byte_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_addr <= bsfr_pkg::RST_STATION_ADDR;
         cfg_ff.max_len      <= bsfr_pkg::RST_MAX_LEN;
         cfg_ff.begin_flag   <= bsfr_pkg::RST_BEGIN_FLAG;
         cfg_ff.esc_flag     <= bsfr_pkg::RST_ESC_FLAG;
         cfg_ff.xor_mask     <= bsfr_pkg::RST_XOR_MASK;
         cfg_ff.crc_poly     <= bsfr_pkg::RST_CRC_POLY;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.kind      = out_ff.kind;
   assign rsp_ch.data      = out_ff.data;
   assign rsp_ch.src_addr  = out_ff.src_addr;
   assign rsp_ch.frame_len = out_ff.frame_len;

   // Checks
   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind != bsfr_pkg::KIND_PAYLOAD) |-> (out_ff.data == '0))
      else $error("status word carries nonzero data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("pending input byte lost while result stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result overwritten");

endmodule

// File: sv/bsfr_deframe.sv
// Deframing state machine: flag hunt, unstuffing, header parse, payload CRC check.
// Uses bsfr_pkg types and crc_byte; advances one byte per step.
module bsfr_deframe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [bsfr_pkg::BYTE_W-1:0]   raw_byte,
   input  bsfr_pkg::cfg_type             cfg,
   output logic                          res_valid,
   output bsfr_pkg::rsp_type             res
);

   bsfr_pkg::phase_type               phase_ff, phase_in;
   logic                              esc_ff, esc_in;
   logic [bsfr_pkg::BYTE_W-1:0]       src_ff, src_in;
   logic [bsfr_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [bsfr_pkg::LEN_W-1:0]        cnt_ff, cnt_in;
   logic [bsfr_pkg::CRC_W-1:0]        crc_ff, crc_in;
   logic [bsfr_pkg::BYTE_W-1:0]       crc_lo_ff, crc_lo_in;

   logic                              have_octet;
   logic [bsfr_pkg::BYTE_W-1:0]       octet;
   logic [bsfr_pkg::LEN_W-1:0]        new_len;
   logic [bsfr_pkg::LEN_W-1:0]        cnt_inc;
   logic [bsfr_pkg::CRC_W-1:0]        crc_next;
   logic                              in_frame;

   assign new_len  = {octet, len_ff[bsfr_pkg::BYTE_W-1:0]};
   assign cnt_inc  = cnt_ff + {{(bsfr_pkg::LEN_W-1){1'b0}}, 1'b1};
   assign crc_next = bsfr_pkg::crc_byte(crc_ff, octet, cfg.crc_poly);
   assign in_frame = (phase_ff == bsfr_pkg::PH_PAYLOAD) ||
                     (phase_ff == bsfr_pkg::PH_CRC_LO) ||
                     (phase_ff == bsfr_pkg::PH_CRC_HI);

   // Unstuffing: flag test wins over the escape test
   always_comb begin
      esc_in     = esc_ff;
      have_octet = 1'b0;
      octet      = raw_byte;
      if (phase_ff == bsfr_pkg::PH_HUNT || raw_byte == cfg.begin_flag) begin
         esc_in = 1'b0;
      end else if (esc_ff) begin
         esc_in     = 1'b0;
         have_octet = 1'b1;
         octet      = raw_byte ^ cfg.xor_mask;
      end else if (raw_byte == cfg.esc_flag) begin
         esc_in = 1'b1;
      end else begin
         have_octet = 1'b1;
      end
   end

   // Phase update and result
   always_comb begin
      phase_in  = phase_ff;
      src_in    = src_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      res_valid = 1'b0;
      res.kind      = bsfr_pkg::KIND_PAYLOAD;
      res.data      = '0;
      res.src_addr  = src_ff;
      res.frame_len = len_ff;
      if (phase_ff == bsfr_pkg::PH_HUNT) begin
         if (raw_byte == cfg.begin_flag) begin
            phase_in = bsfr_pkg::PH_SRC;
         end
      end else if (raw_byte == cfg.begin_flag) begin
         // restart; a frame cut off after its header reports abort
         phase_in = bsfr_pkg::PH_SRC;
         if (in_frame) begin
            res_valid = 1'b1;
            res.kind  = bsfr_pkg::KIND_ABORT;
         end
      end else if (have_octet) begin
         unique case (phase_ff)
            bsfr_pkg::PH_SRC: begin
               src_in   = octet;
               phase_in = bsfr_pkg::PH_DST;
            end
            bsfr_pkg::PH_DST: begin
               phase_in = (octet == cfg.station_addr) ? bsfr_pkg::PH_LEN_LO
                                                      : bsfr_pkg::PH_HUNT;
            end
            bsfr_pkg::PH_LEN_LO: begin
               len_in   = {{(bsfr_pkg::LEN_W-bsfr_pkg::BYTE_W){1'b0}}, octet};
               phase_in = bsfr_pkg::PH_LEN_HI;
            end
            bsfr_pkg::PH_LEN_HI: begin
               len_in = new_len;
               cnt_in = '0;
               crc_in = '0;
               if (new_len > cfg.max_len) begin
                  phase_in = bsfr_pkg::PH_HUNT;
               end else if (new_len == '0) begin
                  phase_in = bsfr_pkg::PH_CRC_LO;
               end else begin
                  phase_in = bsfr_pkg::PH_PAYLOAD;
               end
            end
            bsfr_pkg::PH_PAYLOAD: begin
               crc_in    = crc_next;
               cnt_in    = cnt_inc;
               if (cnt_inc >= len_ff) begin
                  phase_in = bsfr_pkg::PH_CRC_LO;
               end
               res_valid = 1'b1;
               res.kind  = bsfr_pkg::KIND_PAYLOAD;
               res.data  = octet;
            end
            bsfr_pkg::PH_CRC_LO: begin
               crc_lo_in = octet;
               phase_in  = bsfr_pkg::PH_CRC_HI;
            end
            bsfr_pkg::PH_CRC_HI: begin
               phase_in  = bsfr_pkg::PH_HUNT;
               res_valid = 1'b1;
               res.kind  = ({octet, crc_lo_ff} == crc_ff) ? bsfr_pkg::KIND_OK
                                                          : bsfr_pkg::KIND_CRC_ERR;
            end
            default: begin
               phase_in = bsfr_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bsfr_pkg::PH_HUNT;
         esc_ff    <= 1'b0;
         src_ff    <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         crc_ff    <= '0;
         crc_lo_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         src_ff    <= src_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

// File: bench/testbench.sv
// Self-checking bench for byte_stuffed_frame_receiver_core: drives raw link words,
// predicts payload/status words in-bench and compares them as they come out.
// Depends on bsfr_pkg, bsfr_req_if, bsfr_rsp_if and the core itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [bsfr_pkg::CSR_IDX_W-1:0] csr_idx;
   logic [bsfr_pkg::CSR_DAT_W-1:0] csr_wdata;

   bsfr_req_if req_bus ();
   bsfr_rsp_if rsp_bus ();

   byte_stuffed_frame_receiver_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // Deframer prediction state
   bsfr_pkg::cfg_type   regs;
   bsfr_pkg::phase_type rx_phase;
   bit                  esc_armed;
   logic [7:0]          cur_src;
   logic [15:0]         cur_len;
   logic [15:0]         rx_count;
   logic [15:0]         crc_acc;
   logic [7:0]          crc_lo_byte;

   bsfr_pkg::rsp_type   expected_words[$];
   logic [7:0]          link_bytes[$];

   int                  errors = 0;
   int                  sent_words = 0;
   int                  n_payload = 0;
   int                  n_good = 0;
   int                  n_bad_crc = 0;
   int                  n_abort = 0;
   bit                  steady_feed = 1'b0;

   // Result-side back-pressure state
   int                  ready_hold = 0;
   logic                ready_level = 1'b0;

   // Clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Run limit
   initial begin
      #(50ms);
      $display("Timeout: %0d words still expected", expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Reflected CRC-16, one input bit folded in per step
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b,
                                            input logic [15:0] poly);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ b[k];
         c  = c >> 1;
         if (fb) begin
            c = c ^ poly;
         end
      end
      return c;
   endfunction

   // One link word through the deframer; returns 1 when a result word comes out
   function automatic bit deframe_byte(input logic [7:0] raw, output bsfr_pkg::rsp_type w);
      logic [7:0] octet;
      w = '0;
      if (rx_phase == bsfr_pkg::PH_HUNT) begin
         esc_armed = 1'b0;
         if (raw == regs.begin_flag) begin
            rx_phase = bsfr_pkg::PH_SRC;
         end
         return 1'b0;
      end
      // begin flag restarts the frame, raw or after an escape
      if (raw == regs.begin_flag) begin
         esc_armed = 1'b0;
         if (rx_phase inside {bsfr_pkg::PH_PAYLOAD, bsfr_pkg::PH_CRC_LO,
                              bsfr_pkg::PH_CRC_HI}) begin
            w.kind      = bsfr_pkg::KIND_ABORT;
            w.src_addr  = cur_src;
            w.frame_len = cur_len;
            rx_phase    = bsfr_pkg::PH_SRC;
            return 1'b1;
         end
         rx_phase = bsfr_pkg::PH_SRC;
         return 1'b0;
      end
      if (esc_armed) begin
         esc_armed = 1'b0;
         octet     = raw ^ regs.xor_mask;
      end else if (raw == regs.esc_flag) begin
         esc_armed = 1'b1;
         return 1'b0;
      end else begin
         octet = raw;
      end
      case (rx_phase)
         bsfr_pkg::PH_SRC: begin
            cur_src  = octet;
            rx_phase = bsfr_pkg::PH_DST;
         end
         bsfr_pkg::PH_DST: begin
            rx_phase = (octet == regs.station_addr) ? bsfr_pkg::PH_LEN_LO : bsfr_pkg::PH_HUNT;
         end
         bsfr_pkg::PH_LEN_LO: begin
            cur_len  = {8'h00, octet};
            rx_phase = bsfr_pkg::PH_LEN_HI;
         end
         bsfr_pkg::PH_LEN_HI: begin
            cur_len[15:8] = octet;
            rx_count      = '0;
            crc_acc       = '0;
            if (cur_len > regs.max_len) begin
               rx_phase = bsfr_pkg::PH_HUNT;
            end else if (cur_len == 16'd0) begin
               rx_phase = bsfr_pkg::PH_CRC_LO;
            end else begin
               rx_phase = bsfr_pkg::PH_PAYLOAD;
            end
         end
         bsfr_pkg::PH_PAYLOAD: begin
            crc_acc  = crc_step(crc_acc, octet, regs.crc_poly);
            rx_count = rx_count + 16'd1;
            if (rx_count >= cur_len) begin
               rx_phase = bsfr_pkg::PH_CRC_LO;
            end
            w.kind      = bsfr_pkg::KIND_PAYLOAD;
            w.data      = octet;
            w.src_addr  = cur_src;
            w.frame_len = cur_len;
            return 1'b1;
         end
         bsfr_pkg::PH_CRC_LO: begin
            crc_lo_byte = octet;
            rx_phase    = bsfr_pkg::PH_CRC_HI;
         end
         bsfr_pkg::PH_CRC_HI: begin
            rx_phase    = bsfr_pkg::PH_HUNT;
            w.kind      = ({octet, crc_lo_byte} == crc_acc) ? bsfr_pkg::KIND_OK
                                                            : bsfr_pkg::KIND_CRC_ERR;
            w.src_addr  = cur_src;
            w.frame_len = cur_len;
            return 1'b1;
         end
         default: begin
            rx_phase = bsfr_pkg::PH_HUNT;
         end
      endcase
      return 1'b0;
   endfunction

   // Sender gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (steady_feed) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 24);
   endfunction

   // Content byte, biased toward the flag values and the extremes
   function automatic logic [7:0] pick_octet();
      case ($urandom_range(0, 15))
         0: return regs.begin_flag;
         1: return regs.esc_flag;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Declared length: mostly small, some at or just over the limit
   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return 16'd0;
      end
      if (r < 75) begin
         return 16'($urandom_range(1, 8));
      end
      if (r < 88) begin
         return 16'($urandom_range(9, 40));
      end
      if (r < 94) begin
         return (regs.max_len <= 16'd40) ? regs.max_len : 16'($urandom_range(1, 4));
      end
      if (regs.max_len != 16'hFFFF) begin
         return regs.max_len + 16'd1;
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic bsfr_pkg::cfg_type make_cfg(input logic [7:0] la, input logic [15:0] ml,
                                                  input logic [7:0] bf, input logic [7:0] ef,
                                                  input logic [7:0] xm, input logic [15:0] cp);
      bsfr_pkg::cfg_type c;
      c.station_addr = la;
      c.max_len      = ml;
      c.begin_flag   = bf;
      c.esc_flag     = ef;
      c.xor_mask     = xm;
      c.crc_poly     = cp;
      return c;
   endfunction

   // Send one link word, predict its result at the accepting edge
   task automatic send_word(input logic [7:0] b);
      bsfr_pkg::rsp_type w;
      int                gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.raw_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      sent_words++;
      if (deframe_byte(b, w)) begin
         expected_words.push_back(w);
      end
   endtask

   // Stuff a content byte into the pending link stream
   task automatic push_stuffed(input logic [7:0] octet);
      if (octet == regs.begin_flag || octet == regs.esc_flag) begin
         link_bytes.push_back(regs.esc_flag);
         link_bytes.push_back(octet ^ regs.xor_mask);
      end else begin
         link_bytes.push_back(octet);
      end
   endtask

   task automatic flush_link();
      while (link_bytes.size() != 0) begin
         send_word(link_bytes.pop_front());
      end
   endtask

   // Stop sending and let all results and in-flight words clear
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [bsfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write every register while idle; upper bits of the station, begin and escape registers carry junk
   task automatic apply_setting(input bsfr_pkg::cfg_type c);
      logic [7:0] junk;
      wait_idle();
      junk = 8'($urandom_range(0, 255));
      csr_write(bsfr_pkg::CSR_STATION_ADDR, {junk, c.station_addr});
      csr_write(bsfr_pkg::CSR_MAX_LEN, c.max_len);
      csr_write(bsfr_pkg::CSR_BEGIN_FLAG, {~junk, c.begin_flag});
      csr_write(bsfr_pkg::CSR_ESC_FLAG, {junk, c.esc_flag});
      csr_write(bsfr_pkg::CSR_XOR_MASK, {8'h00, c.xor_mask});
      csr_write(bsfr_pkg::CSR_CRC_POLY, c.crc_poly);
      csr_we <= 1'b0;
      regs = c;
   endtask

   // One random sequence: mostly well-formed frames, some noise and cut frames
   task automatic queue_random_frame();
      logic [15:0] len;
      logic [15:0] crc;
      logic [7:0]  octet;
      int          cut;
      steady_feed = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 20) begin
         repeat ($urandom_range(1, 8)) link_bytes.push_back(pick_octet());
         return;
      end
      repeat ($urandom_range(0, 2)) link_bytes.push_back(pick_octet());
      len = pick_length();
      link_bytes.push_back(regs.begin_flag);
      push_stuffed(8'($urandom_range(0, 255)));
      push_stuffed(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : regs.station_addr);
      push_stuffed(len[7:0]);
      push_stuffed(len[15:8]);
      // long lengths get header only
      if (len <= 16'd64) begin
         crc = '0;
         repeat (len) begin
            octet = pick_octet();
            crc   = crc_step(crc, octet, regs.crc_poly);
            push_stuffed(octet);
         end
         if ($urandom_range(0, 4) == 0) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
         end
         push_stuffed(crc[7:0]);
         push_stuffed(crc[15:8]);
      end
      // cut the frame short with a fresh begin flag
      if ($urandom_range(0, 9) == 0 && link_bytes.size() > 2) begin
         cut = $urandom_range(1, link_bytes.size() - 1);
         while (link_bytes.size() > cut) void'(link_bytes.pop_back());
         link_bytes.push_back(regs.begin_flag);
      end
   endtask

   task automatic run_traffic(input int budget);
      int start;
      start = sent_words;
      while (sent_words - start < budget) begin
         queue_random_frame();
         flush_link();
      end
      steady_feed = 1'b0;
   endtask

   // Escape ignored while hunting, zero-length frame, extreme byte values
   task automatic test_hunt_empty_frame();
      link_bytes.push_back(regs.esc_flag);
      link_bytes.push_back(regs.begin_flag);
      link_bytes.push_back(8'hFF);
      link_bytes.push_back(regs.station_addr);
      repeat (4) link_bytes.push_back(8'h00);
      flush_link();
   endtask

   // Payload holding both flag bytes, stuffed, with a wrong CRC
   task automatic test_stuffed_payload();
      logic [15:0] crc;
      crc = crc_step(16'h0000, regs.begin_flag, regs.crc_poly);
      crc = crc_step(crc, regs.esc_flag, regs.crc_poly);
      crc = ~crc;
      link_bytes.push_back(regs.begin_flag);
      push_stuffed(8'h01);
      push_stuffed(regs.station_addr);
      push_stuffed(8'h02);
      push_stuffed(8'h00);
      push_stuffed(regs.begin_flag);
      push_stuffed(regs.esc_flag);
      push_stuffed(crc[7:0]);
      push_stuffed(crc[15:8]);
      flush_link();
   endtask

   // Restarts in payload, header and CRC phases; oversize length; foreign address
   task automatic test_restarts();
      // escaped begin flag inside the payload aborts
      link_bytes.push_back(regs.begin_flag);
      link_bytes.push_back(8'h02);
      link_bytes.push_back(regs.station_addr);
      link_bytes.push_back(8'h03);
      link_bytes.push_back(8'h00);
      link_bytes.push_back(8'hAA);
      link_bytes.push_back(regs.esc_flag);
      link_bytes.push_back(regs.begin_flag);
      // restart in the destination phase is silent
      link_bytes.push_back(8'h03);
      link_bytes.push_back(regs.begin_flag);
      // length 0xFFFF is over the limit
      link_bytes.push_back(8'h03);
      link_bytes.push_back(regs.station_addr);
      link_bytes.push_back(8'hFF);
      link_bytes.push_back(8'hFF);
      // frame for another address
      link_bytes.push_back(regs.begin_flag);
      link_bytes.push_back(8'h04);
      link_bytes.push_back(regs.station_addr ^ 8'h55);
      // restart while waiting for the CRC aborts
      link_bytes.push_back(regs.begin_flag);
      link_bytes.push_back(8'h05);
      link_bytes.push_back(regs.station_addr);
      link_bytes.push_back(8'h00);
      link_bytes.push_back(8'h00);
      link_bytes.push_back(regs.begin_flag);
      flush_link();
   endtask

   task automatic test_default_traffic();
      apply_setting(make_cfg(bsfr_pkg::RST_STATION_ADDR, bsfr_pkg::RST_MAX_LEN,
                             bsfr_pkg::RST_BEGIN_FLAG, bsfr_pkg::RST_ESC_FLAG,
                             bsfr_pkg::RST_XOR_MASK, bsfr_pkg::RST_CRC_POLY));
      run_traffic(200);
   endtask

   task automatic test_extreme_settings();
      apply_setting(make_cfg(8'hFF, 16'h0000, 8'h00, 8'hFF, 8'hFF, 16'hFFFF));
      run_traffic(200);
      apply_setting(make_cfg(8'($urandom_range(0, 255)), 16'hFFFF, 8'hFF, 8'h00, 8'h01,
                             16'h0000));
      run_traffic(200);
   endtask

   // Begin and escape sharing one value, and a zero escape mask
   task automatic test_flag_corner_settings();
      apply_setting(make_cfg(8'h12, 16'd16, 8'h55, 8'h55, 8'h20, 16'h8408));
      run_traffic(200);
      apply_setting(make_cfg(8'h00, 16'd40, 8'h7E, 8'h7D, 8'h00, bsfr_pkg::RST_CRC_POLY));
      run_traffic(200);
   endtask

   task automatic test_random_settings();
      logic [15:0] ml;
      repeat (3) begin
         ml = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 48));
         apply_setting(make_cfg(8'($urandom_range(0, 255)), ml, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535))));
         run_traffic(200);
      end
   endtask

   // Result-side ready: runs of ready, short stalls, a few long stalls
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         case ($urandom_range(0, 15)) inside
            [0:7]: begin
               ready_level = 1'b1;
               ready_hold  = $urandom_range(1, 40);
            end
            [8:13]: begin
               ready_level = 1'b0;
               ready_hold  = $urandom_range(1, 3);
            end
            default: begin
               ready_level = 1'b0;
               ready_hold  = $urandom_range(10, 30);
            end
         endcase
      end
      ready_hold--;
      rsp_bus.ready <= ready_level;
   end

   task automatic report_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
      errors++;
   endtask

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : check_words
      bsfr_pkg::rsp_type exp_w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, kind %0d data 0x%0h src 0x%0h len %0d", $time,
                     rsp_bus.kind, rsp_bus.data, rsp_bus.src_addr, rsp_bus.frame_len);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_bus.kind !== exp_w.kind) begin
               report_field("kind", 16'(exp_w.kind), 16'(rsp_bus.kind));
            end
            if (rsp_bus.data !== exp_w.data) begin
               report_field("data", 16'(exp_w.data), 16'(rsp_bus.data));
            end
            if (rsp_bus.src_addr !== exp_w.src_addr) begin
               report_field("src_addr", 16'(exp_w.src_addr), 16'(rsp_bus.src_addr));
            end
            if (rsp_bus.frame_len !== exp_w.frame_len) begin
               report_field("frame_len", exp_w.frame_len, rsp_bus.frame_len);
            end
            case (exp_w.kind)
               bsfr_pkg::KIND_PAYLOAD: n_payload++;
               bsfr_pkg::KIND_OK:      n_good++;
               bsfr_pkg::KIND_CRC_ERR: n_bad_crc++;
               default:                n_abort++;
            endcase
         end
      end
   end

   // Main sequence
   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_idx          <= bsfr_pkg::CSR_STATION_ADDR;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.raw_byte <= '0;
      regs = make_cfg(bsfr_pkg::RST_STATION_ADDR, bsfr_pkg::RST_MAX_LEN,
                      bsfr_pkg::RST_BEGIN_FLAG, bsfr_pkg::RST_ESC_FLAG,
                      bsfr_pkg::RST_XOR_MASK, bsfr_pkg::RST_CRC_POLY);
      rx_phase    = bsfr_pkg::PH_HUNT;
      esc_armed   = 1'b0;
      cur_src     = '0;
      cur_len     = '0;
      rx_count    = '0;
      crc_acc     = '0;
      crc_lo_byte = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_hunt_empty_frame();
      test_stuffed_payload();
      test_restarts();
      test_default_traffic();
      test_extreme_settings();
      test_flag_corner_settings();
      test_random_settings();
      wait_idle();

      $display("Run covered %0d link words over 8 register settings.", sent_words);
      $display("Checked %0d payload words, %0d good frames, %0d CRC failures, %0d aborts.",
               n_payload, n_good, n_bad_crc, n_abort);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/bsfr_pkg.sv
sv/bsfr_req_if.sv
sv/bsfr_rsp_if.sv
sv/bsfr_deframe.sv
sv/byte_stuffed_frame_receiver_core.sv
bench/testbench.sv
